// File: hw/rtl/nfsa_pkg.sv
// Package: shared constants, codes and types for the next-fit slot allocator.
`timescale 1ns / 1ps

package nfsa_pkg;

	localparam int SLOTS_DEF = 64;
	localparam int SLOT_W    = 6;
	localparam int POOL_W    = 7;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NONE    = 2'd1,
		ST_BAD_REL = 2'd2
	} status_t;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [SLOT_W-1:0] slot;
	} scan_res_t;

endpackage

// File: hw/rtl/nfsa_scan.sv
// Next-fit bit-serial scanner: walks the free map one slot per cycle with one compare unit.
`timescale 1ns / 1ps

module nfsa_scan #(
	parameter int SLOTS = nfsa_pkg::SLOTS_DEF,
	parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	parameter int PW    = $clog2(SLOTS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PW-1:0]       from,
	input  logic [PW-1:0]       pool,
	input  logic                cur_free,
	output logic                busy,
	output logic [IW-1:0]       idx,
	output nfsa_pkg::scan_res_t res
);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t              state_q;
	logic [PW-1:0]       idx_q;
	logic [PW-1:0]       from_q;
	logic                wrap_q;
	nfsa_pkg::scan_res_t res_q;

	logic          hit;
	logic [PW-1:0] idx_inc;
	logic [PW-1:0] limit;
	logic          last;

	always_comb begin
		hit     = cur_free && (idx_q < pool);
		idx_inc = idx_q + PW'(1);
		limit   = wrap_q ? from_q : pool;
		last    = (idx_inc >= limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			from_q  <= '0;
			wrap_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			res_q.done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RUN;
						idx_q   <= from;
						from_q  <= from;
						wrap_q  <= 1'b0;
					end
				end
				S_RUN: begin
					priority if (hit) begin
						state_q     <= S_IDLE;
						res_q.done  <= 1'b1;
						res_q.found <= 1'b1;
						res_q.slot  <= nfsa_pkg::SLOT_W'(idx_q);
					end else if (last && (wrap_q || (from_q == '0))) begin
						state_q     <= S_IDLE;
						res_q.done  <= 1'b1;
						res_q.found <= 1'b0;
						res_q.slot  <= '0;
					end else if (last) begin
						idx_q  <= '0;
						wrap_q <= 1'b1;
					end else begin
						idx_q <= idx_inc;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q == S_RUN);
	assign idx  = idx_q[IW-1:0];
	assign res  = res_q;

endmodule

// File: hw/rtl/next_fit_slot_allocator_top.sv
// Top level: next-fit slot allocator with free bitmap, pointer and result register.
`timescale 1ns / 1ps
// Release: result on done the cycle after start; one release per cycle unless busy.
// Acquire: one slot tested per cycle by the scanner; done is registered from the scan
//   result (pool_size 0 scans one slot), busy high until then, one acquire at a time.
// Results are shown for one cycle and cannot be stalled.
// Async reset clears free map, pointer and pool size: no slot free, every acquire fails.

module next_fit_slot_allocator_top #(
	parameter int SLOTS = nfsa_pkg::SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [nfsa_pkg::SLOT_W-1:0] slot_in,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [nfsa_pkg::SLOT_W-1:0] slot_out,
	input  logic                        pool_size_valid,
	output logic                        pool_size_ready,
	input  logic [nfsa_pkg::POOL_W-1:0] pool_size
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW = $clog2(SLOTS + 1);

	logic [SLOTS-1:0] free_map_q;
	logic [PW-1:0]    next_q;
	logic [PW-1:0]    pool_q;

	logic                        done_q;
	nfsa_pkg::status_t           status_q;
	logic [nfsa_pkg::SLOT_W-1:0] slot_out_q;

	logic                accept;
	logic                acq_go;
	logic                rel_go;
	logic [PW-1:0]       scan_from;
	logic                scan_busy;
	logic [IW-1:0]       scan_idx;
	nfsa_pkg::scan_res_t scan_res;
	logic                rel_bad;
	logic                cfg_we;
	logic [PW-1:0]       cfg_n;
	logic [SLOTS-1:0]    cfg_mask;

	assign accept    = start && !busy;
	assign acq_go    = accept && (operation == nfsa_pkg::OP_ACQUIRE);
	assign rel_go    = accept && (operation == nfsa_pkg::OP_RELEASE);
	assign scan_from = (next_q >= pool_q) ? '0 : next_q;
	assign rel_bad   = ({1'b0, slot_in} >= nfsa_pkg::POOL_W'(pool_q))
	                   || free_map_q[slot_in[IW-1:0]];
	assign cfg_we    = pool_size_valid && pool_size_ready;

	always_comb begin
		if (pool_size > nfsa_pkg::POOL_W'(SLOTS))
			cfg_n = PW'(SLOTS);
		else
			cfg_n = pool_size[PW-1:0];
		for (int i = 0; i < SLOTS; i++)
			cfg_mask[i] = (PW'(i) < cfg_n);
	end

	nfsa_scan #(
		.SLOTS(SLOTS),
		.IW   (IW),
		.PW   (PW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (acq_go),
		.from    (scan_from),
		.pool    (pool_q),
		.cur_free(free_map_q[scan_idx]),
		.busy    (scan_busy),
		.idx     (scan_idx),
		.res     (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_map_q <= '0;
			next_q     <= '0;
			pool_q     <= '0;
			done_q     <= 1'b0;
			status_q   <= nfsa_pkg::ST_OK;
			slot_out_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				free_map_q <= free_map_q | cfg_mask;
				pool_q     <= cfg_n;
			end
			if (acq_go)
				next_q <= scan_from;
			if (rel_go) begin
				done_q     <= 1'b1;
				slot_out_q <= '0;
				if (rel_bad) begin
					status_q <= nfsa_pkg::ST_BAD_REL;
				end else begin
					status_q                      <= nfsa_pkg::ST_OK;
					free_map_q[slot_in[IW-1:0]] <= 1'b1;
				end
			end
			if (scan_res.done) begin
				done_q <= 1'b1;
				if (scan_res.found) begin
					status_q                       <= nfsa_pkg::ST_OK;
					slot_out_q                     <= scan_res.slot;
					free_map_q[scan_res.slot[IW-1:0]] <= 1'b0;
					next_q <= PW'(scan_res.slot) + PW'(1);
				end else begin
					status_q   <= nfsa_pkg::ST_NONE;
					slot_out_q <= '0;
					next_q     <= '0;
				end
			end
		end
	end

	// hold off new words until the scan result has been written back
	assign busy            = scan_busy || scan_res.done;
	assign pool_size_ready = !busy;
	assign done            = done_q;
	assign status          = status_q;
	assign slot_out        = slot_out_q;

endmodule

// File: hw/rtl/nfsa_checker.sv
// Port-level checker for the slot allocator, bound to the top level.
`timescale 1ns / 1ps

module nfsa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        operation,
	input logic                        done,
	input logic [1:0]                  status,
	input logic [nfsa_pkg::SLOT_W-1:0] slot_out
);

	a_rel_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == nfsa_pkg::OP_RELEASE)) |=> (done && !busy))
		else $error("release word not answered in one cycle");

	a_acq_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == nfsa_pkg::OP_ACQUIRE)) |=> (busy && !done))
		else $error("acquire did not start a scan");

	a_scan_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("scan ended without a result word");

	a_fail_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != nfsa_pkg::ST_OK)) |-> (slot_out == '0))
		else $error("nonzero slot on failed result word");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((status == nfsa_pkg::ST_OK) || (status == nfsa_pkg::ST_NONE)
		          || (status == nfsa_pkg::ST_BAD_REL)))
		else $error("illegal status code");

endmodule

bind next_fit_slot_allocator_top nfsa_checker u_nfsa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.operation(operation),
	.done     (done),
	.status   (status),
	.slot_out (slot_out)
);
